// ===== hdl/i2p_pkg.sv =====
// Shared types, character codes and helper functions of the infix-to-postfix converter.
package i2p_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;

  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  localparam logic [1:0] PREC_POW = 2'd3;
  localparam logic [1:0] PREC_MUL = 2'd2;
  localparam logic [1:0] PREC_ADD = 2'd1;
  localparam logic [1:0] PREC_NONE = 2'd0;

  typedef enum logic [2:0] {
    CLS_SKIP,
    CLS_ALNUM,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP
  } cls_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_TOP,
    SRC_CHAR
  } src_t;

  typedef struct packed {
    logic load;
    logic push;
    logic pop;
    logic emit;
    src_t src;
    logic last;
    logic ovf;
    logic unm;
  } cmd_t;

  typedef struct packed {
    logic eoe;
    cls_t cls;
    logic empty;
    logic one;
    logic full;
    logic top_open;
    logic pop_ok;
    logic out_free;
  } sts_t;

  function automatic logic [1:0] prec(input logic [7:0] c);
    logic [1:0] p;
    p = PREC_NONE;
    if (c == CH_CARET) p = PREC_POW;
    else if (c == CH_STAR || c == CH_SLASH) p = PREC_MUL;
    else if (c == CH_PLUS || c == CH_MINUS) p = PREC_ADD;
    return p;
  endfunction

  function automatic cls_t classify(input logic [7:0] c);
    cls_t k;
    k = CLS_OP;
    if (c == CH_SPACE || c == CH_NL) k = CLS_SKIP;
    else if ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
             (c >= CH_LA && c <= CH_LZ)) k = CLS_ALNUM;
    else if (c == CH_LPAREN) k = CLS_OPEN;
    else if (c == CH_RPAREN) k = CLS_CLOSE;
    return k;
  endfunction

endpackage

// ===== hdl/i2p_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module i2p_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/i2p_dp.sv =====
// Datapath: input word register, operator stack with count, output word register.
module i2p_dp #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  i2p_pkg::cmd_t cmd,
  output i2p_pkg::sts_t sts,
  input  logic [7:0]    in_char,
  input  logic          end_of_expr,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          char_valid,
  output logic          last,
  output logic          overflow,
  output logic          unmatched_close
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [7:0]    chr;
  logic          eoe;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] count_m1;
  logic [7:0]    top;
  logic          out_valid_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chr <= in_char;
      eoe <= end_of_expr;
    end
  end

  // top of stack is always being read; valid in the cycle after count settles
  assign count_m1 = count - CW'(1);

  i2p_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (count[AW-1:0]),
    .wdata (chr),
    .raddr (count_m1[AW-1:0]),
    .rdata (top)
  );

  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign sts.eoe      = eoe;
  assign sts.cls      = i2p_pkg::classify(chr);
  assign sts.empty    = (count == '0);
  assign sts.one      = (count == CW'(1));
  assign sts.full     = (count == CW'(STACK_DEPTH));
  assign sts.top_open = (top == i2p_pkg::CH_LPAREN);
  assign sts.pop_ok   = (i2p_pkg::prec(chr) <= i2p_pkg::prec(top));
  assign sts.out_free = !out_valid || out_ready;

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.src)
        i2p_pkg::SRC_TOP:  out_char <= top;
        i2p_pkg::SRC_CHAR: out_char <= chr;
        default:           out_char <= 8'h00;
      endcase
      char_valid      <= (cmd.src != i2p_pkg::SRC_NONE);
      last            <= cmd.last;
      overflow        <= cmd.ovf;
      unmatched_close <= cmd.unm;
    end
  end

endmodule

// ===== hdl/i2p_ctrl.sv =====
// Controller: sequences accept, stack pops and pushes, and result emission per word.
module i2p_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  i2p_pkg::sts_t sts,
  output i2p_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_FETCH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.push   = 1'b0;
    cmd.pop    = 1'b0;
    cmd.emit   = 1'b0;
    cmd.src    = i2p_pkg::SRC_NONE;
    cmd.last   = 1'b0;
    cmd.ovf    = 1'b0;
    cmd.unm    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_FETCH: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.eoe) begin
          if (sts.out_free) begin
            cmd.emit   = 1'b1;
            cmd.src    = sts.empty ? i2p_pkg::SRC_NONE : i2p_pkg::SRC_TOP;
            cmd.last   = sts.empty || sts.one;
            cmd.pop    = !sts.empty;
            state_next = (sts.empty || sts.one) ? S_IDLE : S_FETCH;
          end
        end else begin
          case (sts.cls)
            i2p_pkg::CLS_SKIP: begin
              state_next = S_IDLE;
            end
            i2p_pkg::CLS_ALNUM: begin
              if (sts.out_free) begin
                cmd.emit   = 1'b1;
                cmd.src    = i2p_pkg::SRC_CHAR;
                state_next = S_IDLE;
              end
            end
            i2p_pkg::CLS_OPEN: begin
              if (!sts.full) begin
                cmd.push   = 1'b1;
                state_next = S_IDLE;
              end else if (sts.out_free) begin
                cmd.emit   = 1'b1;
                cmd.ovf    = 1'b1;
                state_next = S_IDLE;
              end
            end
            i2p_pkg::CLS_CLOSE: begin
              if (!sts.empty && !sts.top_open) begin
                if (sts.out_free) begin
                  cmd.emit   = 1'b1;
                  cmd.src    = i2p_pkg::SRC_TOP;
                  cmd.pop    = 1'b1;
                  state_next = S_FETCH;
                end
              end else if (!sts.empty) begin
                cmd.pop    = 1'b1;
                state_next = S_IDLE;
              end else if (sts.out_free) begin
                cmd.emit   = 1'b1;
                cmd.unm    = 1'b1;
                state_next = S_IDLE;
              end
            end
            default: begin
              if (!sts.empty && !sts.top_open && sts.pop_ok) begin
                if (sts.out_free) begin
                  cmd.emit   = 1'b1;
                  cmd.src    = i2p_pkg::SRC_TOP;
                  cmd.pop    = 1'b1;
                  state_next = S_FETCH;
                end
              end else if (!sts.full) begin
                cmd.push   = 1'b1;
                state_next = S_IDLE;
              end else if (sts.out_free) begin
                cmd.emit   = 1'b1;
                cmd.ovf    = 1'b1;
                state_next = S_IDLE;
              end
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/infix_to_postfix_converter_core.sv =====
// Top level of the infix-to-postfix converter: controller and datapath.
//
// Input stream: one expression character per word on s_axis_tdata; s_axis_tlast
// marks an end-of-expression word, whose character is ignored and which flushes
// the operator stack. Output stream: one result per word; m_axis_tlast is set on
// the final word of a flush. Error words carry no character.
// Each input word is accepted, then executed; each operator popped off the stack
// ahead of the word's final step adds a fetch step, as the stack memory has a
// registered read port and a new top of stack is only visible in the cycle after
// the count moves. A flush emits the stack entries one word at a time.
// s_axis_tready is high only between words. The output register holds a word
// while m_axis_tready is low; the block then stalls at the next word it must
// emit.
// Reset empties the stack and the output register; stack contents need no clear.
module infix_to_postfix_converter_core #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // end_of_expr
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_char, [8] char_valid, [9] overflow,
                                      // [10] unmatched_close, [15:11] zero
  output logic        m_axis_tlast    // last
);

  i2p_pkg::cmd_t cmd;
  i2p_pkg::sts_t sts;
  logic [7:0]    out_char;
  logic          char_valid;
  logic          overflow;
  logic          unmatched_close;

  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2p_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_char         (s_axis_tdata),
    .end_of_expr     (s_axis_tlast),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_char        (out_char),
    .char_valid      (char_valid),
    .last            (m_axis_tlast),
    .overflow        (overflow),
    .unmatched_close (unmatched_close)
  );

  assign m_axis_tdata = {5'b0, unmatched_close, overflow, char_valid, out_char};

endmodule

// ===== hdl/i2p_chk.sv =====
// Port-level checker of the infix-to-postfix converter, bound to the top level.
module i2p_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[9] || m_axis_tdata[10]) |->
      !m_axis_tdata[8] && (m_axis_tdata[7:0] == 8'h00) && !m_axis_tlast &&
      !(m_axis_tdata[9] && m_axis_tdata[10]))
    else $error("error word carries a character or both error flags");

  a_no_char: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[8] |-> (m_axis_tdata[7:0] == 8'h00))
    else $error("non-zero character without char_valid");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is in progress");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

endmodule

bind infix_to_postfix_converter_core i2p_chk u_i2p_chk (.*);
